// ===== sv/i2c_interrupt_transfer_sequencer_assert.svh =====
// Assertion macros shared by the sequencer RTL.
// Each macro expects clk_i and rst_ni to be visible in the using module.
`ifndef I2C_INTERRUPT_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_INTERRUPT_TRANSFER_SEQUENCER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ITS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/i2c_its_pkg.sv =====
package i2c_its_pkg;

  localparam int unsigned BufferDepth = 32;
  localparam int unsigned BufIdxW     = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CountW  = 6;
  localparam int unsigned SlotW   = 5;
  localparam int unsigned AddrW   = 7;
  localparam int unsigned StatusW = 16;

  localparam int unsigned SAxisDataW = 56;
  localparam int unsigned SAxisUserW = 2;
  localparam int unsigned MAxisDataW = 32;
  localparam int unsigned MAxisPadW  = 2;

  // Item kinds carried on the slave-side tuser.
  localparam logic [1:0] OpStart = 2'd0;
  localparam logic [1:0] OpLoad  = 2'd1;
  localparam logic [1:0] OpFetch = 2'd2;
  localparam logic [1:0] OpEvent = 2'd3;

  // Status register one flag masks.
  localparam logic [StatusW-1:0] FlagSb    = 16'h0001;
  localparam logic [StatusW-1:0] FlagAddr  = 16'h0002;
  localparam logic [StatusW-1:0] FlagBtf   = 16'h0004;
  localparam logic [StatusW-1:0] FlagStopf = 16'h0010;
  localparam logic [StatusW-1:0] FlagRxne  = 16'h0040;
  localparam logic [StatusW-1:0] FlagTxe   = 16'h0080;
  localparam logic [StatusW-1:0] FlagTxBtf = 16'h0084;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [BufIdxW-1:0] addr;
    logic [ByteW-1:0]   wdata;
  } ram_req_t;

  typedef struct packed {
    logic              wv;
    logic              wsrc_ram;
    logic              fetch;
    logic              start;
    logic              irq_en;
    logic              ack;
    logic              stop;
    logic              pe;
    logic              dbuf;
    logic              devt;
    logic [ByteW-1:0]  frame;
    logic [CountW-1:0] remaining;
  } stage_t;

  // Maps a buffer slot onto the buffer depth through a constant table.
  function automatic logic [BufIdxW-1:0] slot_index(input logic [SlotW-1:0] slot);
    logic [BufIdxW-1:0] wrap_tbl [2**SlotW];
    for (int i = 0; i < 2**SlotW; i++) begin
      wrap_tbl[i] = BufIdxW'(i % BufferDepth);
    end
    return wrap_tbl[slot];
  endfunction

  function automatic logic [BufIdxW-1:0] next_pos(input logic [BufIdxW-1:0] pos);
    return (pos == BufIdxW'(BufferDepth - 1)) ? '0 : BufIdxW'(pos + 1'b1);
  endfunction

endpackage

// ===== sv/i2c_its_ram.sv =====
module i2c_its_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/i2c_its_ctrl.sv =====
// Holds the transfer state and decodes one item per accepted transfer.
module i2c_its_ctrl (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [1:0]                         opcode_i,
  input  logic [i2c_its_pkg::AddrW-1:0]      slave_address_i,
  input  logic                               read_not_write_i,
  input  logic [i2c_its_pkg::CountW-1:0]     byte_count_i,
  input  logic [i2c_its_pkg::SlotW-1:0]      buffer_slot_i,
  input  logic [i2c_its_pkg::ByteW-1:0]      load_byte_i,
  input  logic [i2c_its_pkg::StatusW-1:0]    status_flags_i,
  input  logic                               master_flag_i,
  input  logic [i2c_its_pkg::ByteW-1:0]      received_byte_i,
  output i2c_its_pkg::ram_req_t              ram_req_o,
  output i2c_its_pkg::stage_t                stage_o
);

  logic [i2c_its_pkg::BufIdxW-1:0] pos_q, pos_d;
  logic [i2c_its_pkg::CountW-1:0]  count_q, count_d;
  logic                            dir_q, dir_d;
  logic [i2c_its_pkg::ByteW-1:0]   frame_q, frame_d;

  logic                            f_sb, f_addr, f_stopf, f_rxne, f_txe;
  logic                            tx_only, tx_btf;
  logic [i2c_its_pkg::BufIdxW-1:0] slot_idx;
  logic [i2c_its_pkg::CountW-1:0]  count_dn;

  assign f_sb     = (status_flags_i & i2c_its_pkg::FlagSb) != '0;
  assign f_addr   = (status_flags_i & i2c_its_pkg::FlagAddr) != '0;
  assign f_stopf  = (status_flags_i & i2c_its_pkg::FlagStopf) != '0;
  assign f_rxne   = (status_flags_i & i2c_its_pkg::FlagRxne) != '0;
  assign f_txe    = (status_flags_i & i2c_its_pkg::FlagTxe) != '0;
  assign tx_only  = (status_flags_i & i2c_its_pkg::FlagTxBtf) == i2c_its_pkg::FlagTxe;
  assign tx_btf   = (status_flags_i & i2c_its_pkg::FlagTxBtf) == i2c_its_pkg::FlagTxBtf;
  assign slot_idx = i2c_its_pkg::slot_index(buffer_slot_i);
  assign count_dn = (count_q != '0) ? count_q - 1'b1 : count_q;

  always_comb begin
    pos_d     = pos_q;
    count_d   = count_q;
    dir_d     = dir_q;
    frame_d   = frame_q;
    ram_req_o = '0;
    stage_o   = '0;

    case (opcode_i)
      i2c_its_pkg::OpStart: begin
        frame_d        = {slave_address_i, read_not_write_i};
        dir_d          = read_not_write_i;
        count_d        = byte_count_i;
        stage_o.start  = 1'b1;
        stage_o.irq_en = 1'b1;
      end
      i2c_its_pkg::OpLoad: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.addr  = slot_idx;
        ram_req_o.wdata = load_byte_i;
      end
      i2c_its_pkg::OpFetch: begin
        ram_req_o.re  = 1'b1;
        ram_req_o.addr = slot_idx;
        stage_o.fetch = 1'b1;
      end
      default: begin
        // Peripheral event: slave actions first, then the start bit, then master actions.
        if (!master_flag_i && f_addr) begin
          pos_d = '0;
        end else if (!master_flag_i && f_txe) begin
          ram_req_o.re     = 1'b1;
          ram_req_o.addr   = pos_q;
          pos_d            = i2c_its_pkg::next_pos(pos_q);
          stage_o.wv       = 1'b1;
          stage_o.wsrc_ram = 1'b1;
        end else if (!master_flag_i && f_rxne) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = pos_q;
          ram_req_o.wdata = received_byte_i;
          pos_d           = i2c_its_pkg::next_pos(pos_q);
        end else if (!master_flag_i && f_stopf) begin
          stage_o.pe = 1'b1;
        end else if (f_sb) begin
          stage_o.wv    = 1'b1;
          stage_o.frame = frame_q;
        end else if (master_flag_i && f_addr) begin
          if (!dir_q) begin
            // Address acknowledged in transmit: first byte comes from entry zero.
            ram_req_o.re     = 1'b1;
            ram_req_o.addr   = '0;
            pos_d            = i2c_its_pkg::next_pos('0);
            count_d          = count_dn;
            stage_o.wv       = 1'b1;
            stage_o.wsrc_ram = 1'b1;
            stage_o.dbuf     = (count_dn == '0);
          end else begin
            pos_d        = '0;
            stage_o.ack  = (count_q == 6'd1);
            stage_o.stop = (count_q == 6'd1);
          end
        end else if (master_flag_i && tx_only) begin
          if (count_q != '0) begin
            ram_req_o.re     = 1'b1;
            ram_req_o.addr   = pos_q;
            pos_d            = i2c_its_pkg::next_pos(pos_q);
            count_d          = count_dn;
            stage_o.wv       = 1'b1;
            stage_o.wsrc_ram = 1'b1;
            stage_o.dbuf     = (count_dn == '0);
          end
        end else if (master_flag_i && tx_btf) begin
          stage_o.stop = 1'b1;
          stage_o.devt = 1'b1;
        end else if (master_flag_i && f_rxne) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.addr  = pos_q;
          ram_req_o.wdata = received_byte_i;
          pos_d           = i2c_its_pkg::next_pos(pos_q);
          count_d         = count_dn;
          stage_o.ack     = (count_dn == 6'd1);
          stage_o.stop    = (count_dn == 6'd1);
        end
      end
    endcase

    stage_o.remaining = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      count_q <= '0;
      dir_q   <= 1'b0;
      frame_q <= '0;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      count_q <= count_d;
      dir_q   <= dir_d;
      frame_q <= frame_d;
    end
  end

`include "i2c_interrupt_transfer_sequencer_assert.svh"

  `ITS_ASSERT_NOW(a_ram_single_op, ram_req_o.we, !ram_req_o.re, "buffer read and write in one item")
  `ITS_ASSERT_NEXT(a_state_hold, !accept_i, $stable(pos_q) && $stable(count_q), "state moved without a transfer")

endmodule

// ===== sv/i2c_interrupt_transfer_sequencer.sv =====
// A result passes through the decode stage register and then the output register before it is offered.
// One item per cycle unless the output stalls; the decode stage and output register run back to back.
// The buffer memory has a write port and a registered read port, which sets the two-stage depth.
// Reset clears the buffer position, remaining count, direction and address frame.
// The buffer itself is not cleared: entries are undefined until loaded or received.
module i2c_interrupt_transfer_sequencer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Fields from bit 0 up: slave_address[6:0], read_not_write, byte_count[5:0],
  // buffer_slot[4:0], load_byte[7:0], status_flags[15:0], master_flag,
  // received_byte[7:0], zero fill.
  input  logic [i2c_its_pkg::SAxisDataW-1:0]     s_axis_tdata,
  // Fields from bit 0 up: opcode[1:0].
  input  logic [i2c_its_pkg::SAxisUserW-1:0]     s_axis_tuser,
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0 up: data_write_valid, data_write_byte[7:0], issue_start,
  // enable_interrupts, clear_ack, program_stop, set_enable, disable_buffer_irq,
  // disable_event_irq, fetched_byte[7:0], bytes_remaining[5:0], zero fill.
  output logic [i2c_its_pkg::MAxisDataW-1:0]     m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready
);

  logic                          in_accept;
  logic                          advance;
  i2c_its_pkg::ram_req_t         ram_req;
  i2c_its_pkg::stage_t           stage_d, stage_q;
  logic                          stage_vld_q;
  logic                          out_vld_q;
  logic [i2c_its_pkg::MAxisDataW-1:0] out_data_q, out_data_d;
  logic [i2c_its_pkg::ByteW-1:0] ram_rdata;
  logic [i2c_its_pkg::ByteW-1:0] wr_byte, fetch_byte;

  // A new item enters whenever the decode stage is empty or will move on this cycle.
  // The output register is the skid between the decode stage and the consumer.
  assign advance       = stage_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !stage_vld_q || !out_vld_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  i2c_its_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (in_accept),
    .opcode_i         (s_axis_tuser[1:0]),
    .slave_address_i  (s_axis_tdata[6:0]),
    .read_not_write_i (s_axis_tdata[7]),
    .byte_count_i     (s_axis_tdata[13:8]),
    .buffer_slot_i    (s_axis_tdata[18:14]),
    .load_byte_i      (s_axis_tdata[26:19]),
    .status_flags_i   (s_axis_tdata[42:27]),
    .master_flag_i    (s_axis_tdata[43]),
    .received_byte_i  (s_axis_tdata[51:44]),
    .ram_req_o        (ram_req),
    .stage_o          (stage_d)
  );

  // Reads are only issued with an accepted transfer, so the read data stays put
  // for as long as the decode stage is held by a stalled output.
  i2c_its_ram #(
    .Width (i2c_its_pkg::ByteW),
    .Depth (i2c_its_pkg::BufferDepth)
  ) u_buffer (
    .clk_i   (clk_i),
    .we_i    (in_accept && ram_req.we),
    .waddr_i (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .re_i    (in_accept && ram_req.re),
    .raddr_i (ram_req.addr),
    .rdata_o (ram_rdata)
  );

  // The written byte is either the latched address frame or a buffer entry.
  assign wr_byte    = stage_q.wv ? (stage_q.wsrc_ram ? ram_rdata : stage_q.frame) : '0;
  assign fetch_byte = stage_q.fetch ? ram_rdata : '0;

  assign out_data_d = {{i2c_its_pkg::MAxisPadW{1'b0}}, stage_q.remaining, fetch_byte,
                       stage_q.devt, stage_q.dbuf, stage_q.pe, stage_q.stop, stage_q.ack,
                       stage_q.irq_en, stage_q.start, wr_byte, stage_q.wv};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_vld_q <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (in_accept) begin
        stage_vld_q <= 1'b1;
      end else if (advance) begin
        stage_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_q <= stage_d;
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tdata  = out_data_q;
  assign m_axis_tvalid = out_vld_q;

`include "i2c_interrupt_transfer_sequencer_assert.svh"

  `ITS_ASSERT_NOW(a_no_overrun, in_accept && stage_vld_q, advance, "decode stage overwritten while held")
  `ITS_ASSERT_NEXT(a_stage_fills, in_accept, stage_vld_q, "accepted transfer did not reach decode stage")
  `ITS_ASSERT_NOW(a_read_while_held, stage_vld_q && !advance, !(in_accept && ram_req.re), "buffer read clobbers held data")
  `ITS_ASSERT_NEXT(a_result_follows, advance, m_axis_tvalid, "decoded item not offered")

endmodule
